// ===== rtl/core/lar_pkg.sv =====
// Shared types, widths and the restoring-divide step for the affected-region pipeline.
package lar_pkg;

  localparam int COORD_W         = 10;
  localparam int DIM_W           = 11;
  localparam int KER_W           = 4;
  localparam int STEP_W          = 4;
  localparam int PAD_W           = 3;
  localparam int OUT_W           = 11;
  localparam int DIV_W           = 12;
  localparam int REM_W           = STEP_W;
  localparam int LANES           = 6;
  localparam int DIV_STAGES      = 4;
  localparam int STEPS_PER_STAGE = DIV_W / DIV_STAGES;

  localparam int LANE_ROW_SPAN = 0;
  localparam int LANE_ROW_LO   = 1;
  localparam int LANE_ROW_HI   = 2;
  localparam int LANE_COL_SPAN = 3;
  localparam int LANE_COL_LO   = 4;
  localparam int LANE_COL_HI   = 5;

  localparam logic KIND_CONV = 1'b0;
  localparam logic KIND_POOL = 1'b1;

  typedef struct packed {
    logic               layer_kind;
    logic [KER_W-1:0]   kernel_size;
    logic [STEP_W-1:0]  step_size;
    logic [PAD_W-1:0]   pad_size;
    logic [DIM_W-1:0]   map_height;
    logic [DIM_W-1:0]   map_width;
    logic [COORD_W-1:0] row_first;
    logic [COORD_W-1:0] row_last;
    logic [COORD_W-1:0] col_first;
    logic [COORD_W-1:0] col_last;
  } in_t;

  // work holds the dividend on entry and the quotient after DIV_W steps
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] work;
  } lane_t;

  typedef struct packed {
    logic err;
    logic row_empty;
    logic col_empty;
  } side_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic [STEP_W-1:0] divisor;
    side_t             side;
  } div_t;

  typedef struct packed {
    logic [OUT_W-1:0] row_first;
    logic [OUT_W-1:0] row_last;
    logic [OUT_W-1:0] col_first;
    logic [OUT_W-1:0] col_last;
    logic [OUT_W-1:0] height;
    logic [OUT_W-1:0] width;
    logic             err;
  } res_t;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic lane_t div_step(lane_t l, logic [STEP_W-1:0] d);
    logic [REM_W:0] trial;
    lane_t          r;
    trial  = {l.rem, l.work[DIV_W-1]};
    r.work = {l.work[DIV_W-2:0], 1'b0};
    if (trial >= {1'b0, d}) begin
      r.rem     = REM_W'(trial - {1'b0, d});
      r.work[0] = 1'b1;
    end else begin
      r.rem = trial[REM_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/layer_affected_region.sv =====
// Top level of the layer affected-region pipeline.
//
// For one layer of a sliding-window network (convolution or average pooling)
// each input beat gives kernel, stride, padding, input map size and a changed
// input rectangle; each output beat gives the output map size and the
// rectangle of outputs the change reaches. Per dimension the block computes
// n = (size + 2*pad - kernel) / stride + 1, first = max(0, ceil((start + pad -
// kernel + 1) / stride)) and last = min(n - 1, floor((end + pad) / stride)),
// all with exact integer division. A convolution whose changed interval is
// inverted gives first = 1, last = 0 in that dimension; pooling applies the
// formulas as they stand, so last may fall below first. A zero stride or a
// kernel larger than the padded map sets geometry_error and zeros every other
// field. Output sizes saturate at min(2*MAX_DIM - 1, 2047). The pipeline is
// six register stages deep: an entry stage forming the dividends, four
// stages of a shared-divisor restoring divider (three quotient bits per stage,
// six lanes in parallel), and an output stage doing the clamps. It accepts one
// beat per clock while the output side is not stalled. Every stage holds its
// own valid bit and moves independently, so while the output is stalled the
// input keeps being taken until all six stages are full. There is no state
// between items and no configuration; reset only clears the valid bits.
module layer_affected_region #(
  parameter int MAX_DIM = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // kernel_size[3:0], step_size[7:4], pad_size[10:8], map_height[21:11],
  // map_width[32:22], row_first[42:33], row_last[52:43], col_first[62:53],
  // col_last[72:63], zero[79:73]
  input  logic [79:0] s_tdata,
  // layer_kind[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_row_first[10:0], out_row_last[21:11], out_col_first[32:22],
  // out_col_last[43:33], result_height[54:44], result_width[65:55], zero[71:66]
  output logic [71:0] m_tdata,
  // geometry_error[0]
  output logic        m_tuser
);

  localparam int SIZE_CAP = (2 * MAX_DIM - 1 > 2 ** lar_pkg::OUT_W - 1)
                          ? 2 ** lar_pkg::OUT_W - 1 : 2 * MAX_DIM - 1;

  lar_pkg::in_t  in_item;
  lar_pkg::res_t res;
  lar_pkg::div_t div_data  [lar_pkg::DIV_STAGES+1];
  logic          div_valid [lar_pkg::DIV_STAGES+1];
  logic          div_ready [lar_pkg::DIV_STAGES+1];

  // unpack the input beat
  always_comb begin
    in_item.layer_kind  = s_tuser;
    in_item.kernel_size = s_tdata[3:0];
    in_item.step_size   = s_tdata[7:4];
    in_item.pad_size    = s_tdata[10:8];
    in_item.map_height  = s_tdata[21:11];
    in_item.map_width   = s_tdata[32:22];
    in_item.row_first   = s_tdata[42:33];
    in_item.row_last    = s_tdata[52:43];
    in_item.col_first   = s_tdata[62:53];
    in_item.col_last    = s_tdata[72:63];
  end

  lar_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (in_item),
    .out_valid (div_valid[0]),
    .out_ready (div_ready[0]),
    .out_data  (div_data[0])
  );

  // advance the quotient three bits per stage
  for (genvar g = 0; g < lar_pkg::DIV_STAGES; g++) begin : g_div
    lar_div_stage #(
      .STEPS (lar_pkg::STEPS_PER_STAGE)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_valid[g]),
      .in_ready  (div_ready[g]),
      .in_data   (div_data[g]),
      .out_valid (div_valid[g+1]),
      .out_ready (div_ready[g+1]),
      .out_data  (div_data[g+1])
    );
  end

  lar_post #(
    .SIZE_CAP (SIZE_CAP)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid[lar_pkg::DIV_STAGES]),
    .in_ready  (div_ready[lar_pkg::DIV_STAGES]),
    .in_data   (div_data[lar_pkg::DIV_STAGES]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  // pack the result beat
  assign m_tdata = {6'd0, res.width, res.height, res.col_last, res.col_first,
                    res.row_last, res.row_first};
  assign m_tuser = res.err;

`ifndef SYNTHESIS
  logic all_full;
  assign all_full = div_valid[0] && div_valid[1] && div_valid[2] && div_valid[3]
                  && div_valid[4] && m_tvalid;

  // an error result carries nothing but the flag
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("error result with nonzero payload");

  // a valid geometry always has at least one output row and column
  a_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[54:44] != '0 && m_tdata[65:55] != '0)
    else $error("zero output size without error");

  // with every stage full and the output stalled, input must be held off
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    all_full && !m_tready |-> !s_tready)
    else $error("input taken into a full stalled pipeline");

  // the entry stage flags a zero stride as an error
  a_zero_stride: assert property (@(posedge clk) disable iff (rst)
    div_valid[0] && div_data[0].divisor == '0 |-> div_data[0].side.err)
    else $error("zero stride not flagged");
`endif

endmodule

// ===== rtl/core/lar_prep.sv =====
// Entry stage: forms the six dividends, the empty-interval flags and the error flag.
module lar_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lar_pkg::in_t        in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lar_pkg::div_t       out_data
);

  logic [lar_pkg::DIV_W:0]   row_span;
  logic [lar_pkg::DIV_W:0]   col_span;
  logic [lar_pkg::DIM_W-1:0] row_sp;
  logic [lar_pkg::DIM_W-1:0] col_sp;
  lar_pkg::div_t             nxt;

  always_comb begin
    row_span = (lar_pkg::DIV_W+1)'(in_data.map_height)
             + (lar_pkg::DIV_W+1)'({in_data.pad_size, 1'b0})
             - (lar_pkg::DIV_W+1)'(in_data.kernel_size);
    col_span = (lar_pkg::DIV_W+1)'(in_data.map_width)
             + (lar_pkg::DIV_W+1)'({in_data.pad_size, 1'b0})
             - (lar_pkg::DIV_W+1)'(in_data.kernel_size);
    row_sp = lar_pkg::DIM_W'(in_data.row_first) + lar_pkg::DIM_W'(in_data.pad_size);
    col_sp = lar_pkg::DIM_W'(in_data.col_first) + lar_pkg::DIM_W'(in_data.pad_size);

    nxt = '0;
    nxt.divisor = in_data.step_size;
    nxt.lane[lar_pkg::LANE_ROW_SPAN].work = row_span[lar_pkg::DIV_W-1:0];
    nxt.lane[lar_pkg::LANE_COL_SPAN].work = col_span[lar_pkg::DIV_W-1:0];
    // ceiling of a positive numerator; a numerator at or below zero clamps to 0
    if (row_sp >= lar_pkg::DIM_W'(in_data.kernel_size)) begin
      nxt.lane[lar_pkg::LANE_ROW_LO].work = lar_pkg::DIV_W'(row_sp)
        + lar_pkg::DIV_W'(in_data.step_size) - lar_pkg::DIV_W'(in_data.kernel_size);
    end
    if (col_sp >= lar_pkg::DIM_W'(in_data.kernel_size)) begin
      nxt.lane[lar_pkg::LANE_COL_LO].work = lar_pkg::DIV_W'(col_sp)
        + lar_pkg::DIV_W'(in_data.step_size) - lar_pkg::DIV_W'(in_data.kernel_size);
    end
    nxt.lane[lar_pkg::LANE_ROW_HI].work = lar_pkg::DIV_W'(in_data.row_last)
                                        + lar_pkg::DIV_W'(in_data.pad_size);
    nxt.lane[lar_pkg::LANE_COL_HI].work = lar_pkg::DIV_W'(in_data.col_last)
                                        + lar_pkg::DIV_W'(in_data.pad_size);
    nxt.side.err = (in_data.step_size == '0) || row_span[lar_pkg::DIV_W]
                 || col_span[lar_pkg::DIV_W];
    nxt.side.row_empty = (in_data.layer_kind == lar_pkg::KIND_CONV)
                       && (in_data.row_last < in_data.row_first);
    nxt.side.col_empty = (in_data.layer_kind == lar_pkg::KIND_CONV)
                       && (in_data.col_last < in_data.col_first);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

// ===== rtl/core/lar_div_stage.sv =====
// One divider stage: STEPS restoring steps on all six lanes, then a register.
module lar_div_stage #(
  parameter int STEPS = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lar_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lar_pkg::div_t out_data
);

  lar_pkg::div_t nxt;

  always_comb begin
    nxt = in_data;
    for (int i = 0; i < lar_pkg::LANES; i++) begin
      for (int j = 0; j < STEPS; j++) begin
        nxt.lane[i] = lar_pkg::div_step(nxt.lane[i], in_data.divisor);
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

// ===== rtl/core/lar_post.sv =====
// Output stage: clamps quotients into the region, caps the map size, applies the error rule.
module lar_post #(
  parameter int SIZE_CAP = 2047
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lar_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lar_pkg::res_t out_data
);

  localparam logic [lar_pkg::DIV_W:0] CapWide = (lar_pkg::DIV_W+1)'(SIZE_CAP);

  logic [lar_pkg::DIV_W-1:0] rq_span, rq_lo, rq_hi, cq_span, cq_lo, cq_hi;
  logic [lar_pkg::DIV_W:0]   row_n, col_n;
  lar_pkg::res_t             nxt;

  always_comb begin
    rq_span = in_data.lane[lar_pkg::LANE_ROW_SPAN].work;
    rq_lo   = in_data.lane[lar_pkg::LANE_ROW_LO].work;
    rq_hi   = in_data.lane[lar_pkg::LANE_ROW_HI].work;
    cq_span = in_data.lane[lar_pkg::LANE_COL_SPAN].work;
    cq_lo   = in_data.lane[lar_pkg::LANE_COL_LO].work;
    cq_hi   = in_data.lane[lar_pkg::LANE_COL_HI].work;
    row_n   = (lar_pkg::DIV_W+1)'(rq_span) + 1'b1;
    col_n   = (lar_pkg::DIV_W+1)'(cq_span) + 1'b1;

    nxt = '0;
    if (in_data.side.err) begin
      nxt.err = 1'b1;
    end else begin
      nxt.height = (row_n > CapWide) ? lar_pkg::OUT_W'(SIZE_CAP) : lar_pkg::OUT_W'(row_n);
      nxt.width  = (col_n > CapWide) ? lar_pkg::OUT_W'(SIZE_CAP) : lar_pkg::OUT_W'(col_n);
      if (in_data.side.row_empty) begin
        nxt.row_first = lar_pkg::OUT_W'(1);
      end else begin
        nxt.row_first = lar_pkg::OUT_W'(rq_lo);
        nxt.row_last  = (rq_hi > rq_span) ? lar_pkg::OUT_W'(rq_span) : lar_pkg::OUT_W'(rq_hi);
      end
      if (in_data.side.col_empty) begin
        nxt.col_first = lar_pkg::OUT_W'(1);
      end else begin
        nxt.col_first = lar_pkg::OUT_W'(cq_lo);
        nxt.col_last  = (cq_hi > cq_span) ? lar_pkg::OUT_W'(cq_span) : lar_pkg::OUT_W'(cq_hi);
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

// ===== tb/sv/layer_affected_region_tb.sv =====
// Self-checking testbench for the layer affected-region pipeline.
`timescale 1ns / 100ps

module layer_affected_region_tb;
  import lar_pkg::*;

  localparam int MAX_DIM     = 1024;
  localparam int SIZE_CAP    = (2 * MAX_DIM - 1 > 2047) ? 2047 : 2 * MAX_DIM - 1;
  localparam int IDLE_LIMIT  = 5000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES = 400;   // long output hold-off for the backpressure test
  localparam int DRAIN_TAIL  = 12;    // longer than a pass through the six-stage pipeline
  localparam int MAX_REPORTS = 10;

  // One layer description, as the sender sees it.
  typedef struct packed {
    logic               kind;
    logic [KER_W-1:0]   kernel;
    logic [STEP_W-1:0]  step;
    logic [PAD_W-1:0]   pad;
    logic [DIM_W-1:0]   height;
    logic [DIM_W-1:0]   width;
    logic [COORD_W-1:0] row_first;
    logic [COORD_W-1:0] row_last;
    logic [COORD_W-1:0] col_first;
    logic [COORD_W-1:0] col_last;
  } layer_t;

  // One affected-region answer, as the receiver sees it.
  typedef struct packed {
    logic [OUT_W-1:0] row_first;
    logic [OUT_W-1:0] row_last;
    logic [OUT_W-1:0] col_first;
    logic [OUT_W-1:0] col_last;
    logic [OUT_W-1:0] height;
    logic [OUT_W-1:0] width;
    logic             err;
  } region_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // kernel_size[3:0], step_size[7:4], pad_size[10:8], map_height[21:11],
  // map_width[32:22], row_first[42:33], row_last[52:43], col_first[62:53],
  // col_last[72:63], zero[79:73]
  logic [79:0] s_tdata  = '0;
  // layer_kind[0]
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // out_row_first[10:0], out_row_last[21:11], out_col_first[32:22],
  // out_col_last[43:33], result_height[54:44], result_width[65:55], zero[71:66]
  logic [71:0] m_tdata;
  // geometry_error[0]
  logic        m_tuser;

  // Answers still owed by the block, oldest first.
  region_t region_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;   // bumped by a test to ask for one long hold-off
  int hold_served   = 0;
  int hold_left     = 0;

  int error_count   = 0;
  int layers_sent   = 0;
  int regions_seen  = 0;
  int geo_errors    = 0;
  int empty_reaches = 0;
  int quiet_cycles  = 0;

  layer_affected_region #(
    .MAX_DIM (MAX_DIM)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Reach of a changed interval [s, e] along one dimension. Returns 0 when the
  // geometry is invalid (zero stride, or kernel wider than the padded map).
  function automatic bit dim_reach(input bit is_conv, input int size, s, e, k, t, p,
                                   output int first, output int last, output int n);
    int span;
    int num;
    first = 0;
    last  = 0;
    n     = 0;
    span  = size + 2 * p - k;
    if (t == 0 || span < 0) return 1'b0;
    n = span / t + 1;
    if (is_conv && e < s) begin
      // inverted convolution interval: force the empty pair
      first = 1;
      last  = 0;
    end else begin
      num   = s + p - k + 1;
      first = (num >= 0) ? (num + t - 1) / t : -((-num) / t);
      if (first < 0) first = 0;
      last = (e + p) / t;
      if (last > n - 1) last = n - 1;
    end
    return 1'b1;
  endfunction

  function automatic region_t predict_region(layer_t it);
    region_t r;
    bit      conv;
    bit      ok_r;
    bit      ok_c;
    int      rf, rl, oh, cf, cl, ow;
    conv = (it.kind == KIND_CONV);
    ok_r = dim_reach(conv, int'(it.height), int'(it.row_first), int'(it.row_last),
                     int'(it.kernel), int'(it.step), int'(it.pad), rf, rl, oh);
    ok_c = dim_reach(conv, int'(it.width), int'(it.col_first), int'(it.col_last),
                     int'(it.kernel), int'(it.step), int'(it.pad), cf, cl, ow);
    r = '0;
    if (!ok_r || !ok_c) begin
      // any invalid dimension zeros the whole answer and raises the flag
      r.err = 1'b1;
      return r;
    end
    r.row_first = OUT_W'(rf);
    r.row_last  = OUT_W'(rl);
    r.col_first = OUT_W'(cf);
    r.col_last  = OUT_W'(cl);
    r.height    = OUT_W'((oh > SIZE_CAP) ? SIZE_CAP : oh);
    r.width     = OUT_W'((ow > SIZE_CAP) ? SIZE_CAP : ow);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic layer_t make_layer(logic kind, int k, int t, int p, int h, int w,
                                        int r0, int r1, int c0, int c1);
    layer_t it;
    it.kind      = kind;
    it.kernel    = KER_W'(k);
    it.step      = STEP_W'(t);
    it.pad       = PAD_W'(p);
    it.height    = DIM_W'(h);
    it.width     = DIM_W'(w);
    it.row_first = COORD_W'(r0);
    it.row_last  = COORD_W'(r1);
    it.col_first = COORD_W'(c0);
    it.col_last  = COORD_W'(c1);
    return it;
  endfunction

  // Pick a changed interval inside a map of the given size, mostly in order,
  // now and then inverted.
  function automatic void pick_interval(input int size, output int first, output int last);
    int a;
    int b;
    a = $urandom_range(size - 1);
    b = $urandom_range(size - 1);
    first = (a < b) ? a : b;
    last  = (a < b) ? b : a;
    if ($urandom_range(9) == 0) begin
      first = last;
      last  = (a < b) ? a : b;
    end
  endfunction

  function automatic layer_t rand_layer();
    layer_t it;
    int     h, w, r0, r1, c0, c1;
    if ($urandom_range(99) < 12) begin
      // raw noise: every field over its full bit range
      it = make_layer(1'($urandom_range(1)), $urandom_range(15), $urandom_range(15),
                      $urandom_range(7), $urandom_range(2047), $urandom_range(2047),
                      $urandom_range(1023), $urandom_range(1023),
                      $urandom_range(1023), $urandom_range(1023));
    end else begin
      // random layer, now and then with a zero stride; small maps are favored now and then
      h = ($urandom_range(2) == 0) ? $urandom_range(24, 1) : $urandom_range(1024, 1);
      w = ($urandom_range(2) == 0) ? $urandom_range(24, 1) : $urandom_range(1024, 1);
      pick_interval(h, r0, r1);
      pick_interval(w, c0, c1);
      it = make_layer(1'($urandom_range(1)), $urandom_range(15, 1),
                      ($urandom_range(49) == 0) ? 0 : $urandom_range(15, 1),
                      $urandom_range(7), h, w, r0, r1, c0, c1);
    end
    return it;
  endfunction

  // Offer one layer beat, idling first at the current sender rate, and log the
  // expected answer once the beat is taken.
  task automatic send_layer(layer_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= {7'd0, it.col_last, it.col_first, it.row_last, it.row_first,
                 it.width, it.height, it.pad, it.step, it.kernel};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    region_q.push_back(predict_region(it));
    layers_sent++;
  endtask

  // Drop valid so the last beat is not taken again, then wait for all answers.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (region_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    send_idle_pct = 24;
    recv_idle_pct = 62;
    // smallest legal layer, single-pixel change
    send_layer(make_layer(KIND_CONV, 1, 1, 0, 1, 1, 0, 0, 0, 0));
    // every field at its top value
    send_layer(make_layer(KIND_POOL, 15, 15, 7, 2047, 2047, 1023, 1023, 1023, 1023));
    // whole map changed
    send_layer(make_layer(KIND_CONV, 3, 1, 1, 1024, 1024, 0, 1023, 0, 1023));
    // zero stride, both kinds
    send_layer(make_layer(KIND_CONV, 3, 0, 1, 64, 64, 2, 9, 3, 7));
    send_layer(make_layer(KIND_POOL, 2, 0, 0, 64, 64, 2, 9, 3, 7));
    // kernel wider than the padded map, rows only, then columns only, then both
    send_layer(make_layer(KIND_CONV, 15, 1, 0, 4, 64, 0, 3, 0, 63));
    send_layer(make_layer(KIND_POOL, 15, 2, 0, 64, 4, 0, 63, 0, 3));
    send_layer(make_layer(KIND_CONV, 2, 1, 0, 1, 1, 0, 0, 0, 0));
    // zero kernel and zero map size go through the formulas unchanged
    send_layer(make_layer(KIND_CONV, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    send_layer(make_layer(KIND_POOL, 0, 3, 2, 10, 10, 5, 2, 1, 8));
    // inverted convolution interval in rows, then in columns
    send_layer(make_layer(KIND_CONV, 3, 2, 1, 32, 32, 20, 5, 3, 9));
    send_layer(make_layer(KIND_CONV, 3, 2, 1, 32, 32, 3, 9, 20, 5));
    // inverted pooling interval: no empty-pair override
    send_layer(make_layer(KIND_POOL, 3, 2, 1, 32, 32, 20, 5, 20, 5));
    // output size beyond the cap saturates
    send_layer(make_layer(KIND_CONV, 1, 1, 7, 2047, 2047, 0, 1023, 0, 1023));
    // change far outside the map: empty reach after the clamp
    send_layer(make_layer(KIND_POOL, 2, 2, 0, 10, 10, 1000, 1023, 1000, 1023));
    // map edges
    send_layer(make_layer(KIND_CONV, 5, 3, 2, 100, 50, 0, 0, 49, 49));
    send_layer(make_layer(KIND_POOL, 15, 15, 7, 15, 15, 0, 14, 14, 14));
    send_layer(make_layer(KIND_CONV, 1, 15, 0, 1024, 1024, 1023, 1023, 0, 1023));
    wait_drain();
  endtask

  task automatic test_random(int count, int sender_pct, int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    repeat (count) send_layer(rand_layer());
    wait_drain();
  endtask

  // Hold the output off for a long stretch while beats keep coming, so the
  // pipeline fills and stalls its input, then let it drain.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    repeat (40) send_layer(rand_layer());
    wait_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Output side: check each result beat and drive tready for the next edge.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_side
    region_t got;
    region_t want;
    logic [5:0] spare;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      {spare, got.width, got.height, got.col_last, got.col_first,
       got.row_last, got.row_first} = m_tdata;
      got.err = m_tuser;
      regions_seen++;
      if (region_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result beat with no layer pending: %h", $realtime, got);
      end else begin
        want = region_q.pop_front();
        if (want.err) geo_errors++;
        else if (want.row_last < want.row_first || want.col_last < want.col_first)
          empty_reaches++;
        if (got.row_first !== want.row_first || got.row_last !== want.row_last ||
            got.col_first !== want.col_first || got.col_last !== want.col_last ||
            got.height !== want.height || got.width !== want.width ||
            got.err !== want.err) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: mismatch rows %0d..%0d/%0d..%0d cols %0d..%0d/%0d..%0d",
                     $realtime, want.row_first, want.row_last, got.row_first, got.row_last,
                     want.col_first, want.col_last, got.col_first, got.col_last);
            $display("  size %0dx%0d/%0dx%0d err %0b/%0b (expected/actual)",
                     want.height, want.width, got.height, got.width, want.err, got.err);
          end
        end
      end
    end
    // pick up a hold-off request, then drive ready for the next cycle
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $realtime, IDLE_LIMIT, region_q.size());
      $display("layer_affected_region_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(600, 24, 62);
    test_random(600, 62, 24);
    test_backpressure();
    test_random(450, 0, 0);

    wait_drain();
    // catch any stray beats after the last expected one
    repeat (DRAIN_TAIL) @(posedge clk);
    if (region_q.size() != 0) begin
      error_count++;
      $display("%0d expected results never arrived", region_q.size());
    end

    $display("covered %0d layer beats and %0d result beats: %0d geometry errors, %0d empty",
             layers_sent, regions_seen, geo_errors, empty_reaches);
    $display("reaches, stalls on both sides and one long output hold-off; %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("layer_affected_region_tb: clean");
    end else begin
      $display("layer_affected_region_tb: errors");
    end
    $finish;
  end

endmodule
